@@ design/chbd_pkg.sv @@
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types and constants for the canonical Huffman bit decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

  // input beat function codes
  typedef enum logic [1:0] {
    FUNC_DECODE      = 2'd0,
    FUNC_LOAD_COUNT  = 2'd1,
    FUNC_LOAD_SYMBOL = 2'd2,
    FUNC_RESTART     = 2'd3
  } func_e;

  // result status codes
  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_INVALID = 1'b1
  } status_e;

  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 16;
  localparam int LEN_W      = 5;
  localparam int FIRST_W    = 17;
  localparam int BASE_W     = 9;
  localparam int COUNT_DEPTH = 16;
  localparam int COUNT_AW   = 4;

  localparam logic [FIRST_W-1:0] FIRST_MAX = 17'h1FFFF;
  localparam logic [BASE_W-1:0]  BASE_MAX  = 9'h1FF;

  // completed code info passed from decode to the output stage
  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] code_length;
  } res_meta_t;

endpackage

@@ design/chbd_if.sv @@
// ----------------------------------------------------------------------------
// chbd_in_if / chbd_out_if
// Valid/ready channels carrying input beats and decoded result beats.
// ----------------------------------------------------------------------------
interface chbd_in_if
  import chbd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              bit_req;
  logic [BYTE_W-1:0] table_index;
  logic [BYTE_W-1:0] table_value;

  modport source (output valid, func, bit_req, table_index, table_value, input ready);
  modport sink   (input valid, func, bit_req, table_index, table_value, output ready);
endinterface

interface chbd_out_if
  import chbd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] symbol;
  logic [LEN_W-1:0]  code_length;
  logic              status;

  modport source (output valid, symbol, code_length, status, input ready);
  modport sink   (input valid, symbol, code_length, status, output ready);
endinterface

@@ design/canonical_huffman_bit_decoder_top.sv @@
// A result beat is registered in the read stage, then in the output register once it is free.
// One input beat per cycle unless stalled; the count lookup and range check are combinational.
// The symbol store read (one port, registered data) fills the middle stage.
// Reset clears the partial code state and the output stages; tables are undefined until loaded.
// ----------------------------------------------------------------------------
// canonical_huffman_bit_decoder_top
// Bit-serial canonical Huffman decoder with loadable count and symbol tables.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder_top
  import chbd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 16,
  parameter int SYMBOL_SLOTS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chbd_in_if.sink    in_i,
  chbd_out_if.source out_o
);

  localparam int AW = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;

  logic              accept;
  logic              can_accept;
  logic              res_new;
  res_meta_t         res_meta;
  logic              sym_re;
  logic [AW-1:0]     sym_raddr;
  logic              sym_we;
  logic [AW-1:0]     sym_waddr;
  logic [BYTE_W-1:0] sym_wdata;
  logic [BYTE_W-1:0] sym_rdata;

  assign in_i.ready = can_accept;
  assign accept     = in_i.valid && can_accept;

  // per-bit decode and table state
  chbd_decode #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .SYMBOL_SLOTS  (SYMBOL_SLOTS),
    .AW            (AW)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (in_i.func),
    .bit_i       (in_i.bit_req),
    .index_i     (in_i.table_index),
    .value_i     (in_i.table_value),
    .res_new_o   (res_new),
    .res_meta_o  (res_meta),
    .sym_re_o    (sym_re),
    .sym_raddr_o (sym_raddr),
    .sym_we_o    (sym_we),
    .sym_waddr_o (sym_waddr),
    .sym_wdata_o (sym_wdata)
  );

  // symbol store
  chbd_sym_ram #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS),
    .AW           (AW)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (sym_waddr),
    .wdata_i (sym_wdata),
    .re_i    (sym_re),
    .raddr_i (sym_raddr),
    .rdata_o (sym_rdata)
  );

  // read stage and output register
  chbd_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_new_i    (res_new),
    .res_meta_i   (res_meta),
    .rdata_i      (sym_rdata),
    .out_ready_i  (out_o.ready),
    .can_accept_o (can_accept),
    .out_valid_o  (out_o.valid),
    .out_symbol_o (out_o.symbol),
    .out_len_o    (out_o.code_length),
    .out_status_o (out_o.status)
  );

  // results only come from accepted decode beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_new |-> accept && (in_i.func == FUNC_DECODE))
    else $error("result raised without an accepted decode beat");

  // a symbol read is issued only for a valid completed code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_re |-> res_new && (res_meta.status == STATUS_OK))
    else $error("symbol read without a matched code");

  // store writes and reads never collide in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sym_we && sym_re))
    else $error("symbol store read and write in the same cycle");

  // an invalid result carries a zero symbol and a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == STATUS_INVALID) |->
      (out_o.symbol == '0) && (out_o.code_length != '0))
    else $error("invalid result with nonzero symbol or zero length");

endmodule

@@ design/chbd_sym_ram.sv @@
// ----------------------------------------------------------------------------
// chbd_sym_ram
// Symbol store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chbd_sym_ram
  import chbd_pkg::*;
#(
  parameter int SYMBOL_SLOTS = 256,
  parameter int AW = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [SYMBOL_SLOTS];
  logic [BYTE_W-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/chbd_decode.sv @@
// ----------------------------------------------------------------------------
// chbd_decode
// Length count table, partial code state and the per-bit range check.
// Issues the symbol store read for a matched code.
// ----------------------------------------------------------------------------
module chbd_decode
  import chbd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 16,
  parameter int SYMBOL_SLOTS = 256,
  parameter int AW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic              bit_i,
  input  logic [BYTE_W-1:0] index_i,
  input  logic [BYTE_W-1:0] value_i,
  output logic              res_new_o,
  output res_meta_t         res_meta_o,
  output logic              sym_re_o,
  output logic [AW-1:0]     sym_raddr_o,
  output logic              sym_we_o,
  output logic [AW-1:0]     sym_waddr_o,
  output logic [BYTE_W-1:0] sym_wdata_o
);

  func_e func;

  logic [BYTE_W-1:0]  count_q [COUNT_DEPTH];
  logic [CODE_W-1:0]  code_q, code_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [FIRST_W-1:0] first_q, first_d;
  logic [BASE_W-1:0]  base_q, base_d;

  logic [BYTE_W-1:0]  cur_count;
  logic [CODE_W-1:0]  code_next;
  logic [LEN_W-1:0]   len_next;
  logic [FIRST_W-1:0] diff;
  logic               in_range;
  logic [BASE_W:0]    slot;
  logic               slot_ok;
  logic               too_long;
  logic [FIRST_W:0]   first_sum;
  logic [FIRST_W+1:0] first_shl;
  logic [FIRST_W-1:0] first_sat;
  logic [BASE_W:0]    base_sum;
  logic [BASE_W-1:0]  base_sat;
  logic               is_decode;

  assign func      = func_e'(func_i);
  assign is_decode = accept_i && (func == FUNC_DECODE);

  // count table writes, out-of-range indexes dropped
  always_ff @(posedge clk_i) begin
    if (accept_i && (func == FUNC_LOAD_COUNT) && (index_i[BYTE_W-1:COUNT_AW] == '0)) begin
      count_q[index_i[COUNT_AW-1:0]] <= value_i;
    end
  end

  // count for the length under test; old length is always below sixteen
  assign cur_count = count_q[len_q[COUNT_AW-1:0]];

  // extend the partial code and test its range
  always_comb begin
    code_next = {code_q[CODE_W-2:0], bit_i};
    len_next  = len_q + LEN_W'(1);
    diff      = {1'b0, code_next} - first_q;
    in_range  = ({1'b0, code_next} >= first_q) &&
                (diff < {{(FIRST_W-BYTE_W){1'b0}}, cur_count});
    slot      = {1'b0, base_q} + {{(BASE_W+1-BYTE_W){1'b0}}, diff[BYTE_W-1:0]};
    slot_ok   = slot < (BASE_W+1)'(SYMBOL_SLOTS);
    too_long  = len_next >= LEN_W'(MAX_CODE_BITS);
  end

  // saturating advance of first code and symbol base
  always_comb begin
    first_sum = {1'b0, first_q} + {{(FIRST_W+1-BYTE_W){1'b0}}, cur_count};
    first_shl = {first_sum, 1'b0};
    first_sat = (first_shl > {2'b00, FIRST_MAX}) ? FIRST_MAX : first_shl[FIRST_W-1:0];
    base_sum  = {1'b0, base_q} + {{(BASE_W+1-BYTE_W){1'b0}}, cur_count};
    base_sat  = (base_sum > {1'b0, BASE_MAX}) ? BASE_MAX : base_sum[BASE_W-1:0];
  end

  // next state of the partial code
  always_comb begin
    code_d  = code_q;
    len_d   = len_q;
    first_d = first_q;
    base_d  = base_q;
    if (accept_i) begin
      unique case (func)
        FUNC_DECODE: begin
          if (in_range || too_long) begin
            code_d  = '0;
            len_d   = '0;
            first_d = '0;
            base_d  = '0;
          end else begin
            code_d  = code_next;
            len_d   = len_next;
            first_d = first_sat;
            base_d  = base_sat;
          end
        end
        FUNC_RESTART: begin
          code_d  = '0;
          len_d   = '0;
          first_d = '0;
          base_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= '0;
      len_q   <= '0;
      first_q <= '0;
      base_q  <= '0;
    end else begin
      code_q  <= code_d;
      len_q   <= len_d;
      first_q <= first_d;
      base_q  <= base_d;
    end
  end

  // result and symbol store requests
  always_comb begin
    res_new_o              = is_decode && (in_range || too_long);
    res_meta_o.status      = (in_range && slot_ok) ? STATUS_OK : STATUS_INVALID;
    res_meta_o.code_length = in_range ? len_next : LEN_W'(MAX_CODE_BITS);
    sym_re_o               = is_decode && in_range && slot_ok;
    sym_raddr_o            = slot[AW-1:0];
    sym_we_o               = accept_i && (func == FUNC_LOAD_SYMBOL) &&
                             ({1'b0, index_i} < (BYTE_W+1)'(SYMBOL_SLOTS));
    sym_waddr_o            = index_i[AW-1:0];
    sym_wdata_o            = value_i;
  end

endmodule

@@ design/chbd_out_stage.sv @@
// ----------------------------------------------------------------------------
// chbd_out_stage
// Holds a result across the symbol store read, then in an output register.
// ----------------------------------------------------------------------------
module chbd_out_stage
  import chbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_new_i,
  input  res_meta_t         res_meta_i,
  input  logic [BYTE_W-1:0] rdata_i,
  input  logic              out_ready_i,
  output logic              can_accept_o,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_symbol_o,
  output logic [LEN_W-1:0]  out_len_o,
  output logic              out_status_o
);

  logic              res_valid_q, res_valid_d;
  res_meta_t         res_meta_q;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_symbol_q;
  logic [LEN_W-1:0]  out_len_q;
  logic              out_status_q;
  logic              res_adv;

  // move the read stage into the output register when it is free
  assign res_adv      = res_valid_q && (!out_valid_q || out_ready_i);
  assign can_accept_o = !res_valid_q || res_adv;

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_new_i) begin
      res_valid_d = 1'b1;
    end else if (res_adv) begin
      res_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (res_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (res_new_i) begin
      res_meta_q <= res_meta_i;
    end
    if (res_adv) begin
      out_symbol_q <= (res_meta_q.status == STATUS_OK) ? rdata_i : '0;
      out_len_q    <= res_meta_q.code_length;
      out_status_q <= res_meta_q.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_symbol_q;
  assign out_len_o    = out_len_q;
  assign out_status_o = out_status_q;

endmodule
